[sv/floppy_controller_no_drive_macros.svh]
// Assertion macros used by the floppy controller core.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef FLOPPY_CONTROLLER_NO_DRIVE_MACROS_SVH
`define FLOPPY_CONTROLLER_NO_DRIVE_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define FDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true outside reset.
`define FDC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[sv/fdc_pkg.sv]
// Types, codes and constants of the floppy controller register interface.
// Depends on nothing; the controller modules import it.
package fdc_pkg;

    typedef enum logic [1:0] {
        FUNC_RD_STATUS = 2'd0,
        FUNC_RD_DATA   = 2'd1,
        FUNC_WR_DATA   = 2'd2,
        FUNC_WR_DRIVE  = 2'd3
    } func_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] write_byte;
    } req_t;

    localparam logic [4:0] OP_READ_TRACK  = 5'h02;
    localparam logic [4:0] OP_SPECIFY     = 5'h03;
    localparam logic [4:0] OP_SENSE_DRIVE = 5'h04;
    localparam logic [4:0] OP_WRITE_DATA  = 5'h05;
    localparam logic [4:0] OP_READ_DATA   = 5'h06;
    localparam logic [4:0] OP_RECALIBRATE = 5'h07;
    localparam logic [4:0] OP_SENSE_INT   = 5'h08;
    localparam logic [4:0] OP_WRITE_DEL   = 5'h09;
    localparam logic [4:0] OP_READ_ID     = 5'h0A;
    localparam logic [4:0] OP_READ_DEL    = 5'h0C;
    localparam logic [4:0] OP_FORMAT      = 5'h0D;
    localparam logic [4:0] OP_SEEK        = 5'h0F;

    localparam logic [7:0] MSR_RESULT   = 8'hD0;
    localparam logic [7:0] MSR_BUSY     = 8'h90;
    localparam logic [7:0] MSR_IDLE     = 8'h80;
    localparam logic [7:0] ST0_INVALID  = 8'hC0;
    localparam logic [7:0] ST0_SEEK_END = 8'h70;

    // Command bytes beyond this count are dropped.
    localparam logic [3:0] MAX_CMD_BYTES = 4'd9;

    // Number of parameter bytes that follow a command's first byte.
    function automatic logic [3:0] param_count(input logic [4:0] op);
        logic [3:0] n;
        unique case (op) inside
            OP_SPECIFY, OP_SEEK:                          n = 4'd2;
            OP_SENSE_DRIVE, OP_RECALIBRATE, OP_READ_ID:   n = 4'd1;
            OP_FORMAT:                                    n = 4'd5;
            OP_READ_TRACK, OP_WRITE_DATA, OP_READ_DATA,
            OP_WRITE_DEL, OP_READ_DEL:                    n = 4'd8;
            default:                                      n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

[sv/fdc_if.sv]
// Valid/ready channel interfaces of the floppy controller: the bus access
// channel and the response channel. No dependencies.
interface fdc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] write_byte;

    modport source (output valid, func, write_byte, input ready);
    modport sink   (input valid, func, write_byte, output ready);
endinterface

interface fdc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       irq_pending;

    modport source (output valid, read_byte, irq_pending, input ready);
    modport sink   (input valid, read_byte, irq_pending, output ready);
endinterface

[sv/floppy_controller_no_drive.sv]
// Top level of the 765-style floppy controller register interface, no drive attached.
// Depends on fdc_pkg, fdc_if, fdc_in_stage and fdc_core.
//
// Usage: each transfer on req is one bus access. req.func selects read main
// status, read result byte, write command/parameter byte or write drive
// control; req.write_byte carries the byte for the two writes. Every access
// gives exactly one transfer on rsp: rsp.read_byte holds the status or result
// byte on reads and zero on writes, rsp.irq_pending the interrupt pending flag
// after the access.
// Path: the access is held in the input register and is then decoded into
// the response register, which offers it on rsp.
// Throughput: one access per cycle while rsp is not stalled; the core decodes
// each access and updates its state as it takes it.
// Reset puts the controller in the command phase with no interrupt pending,
// drive zero selected and both channels empty.
// When the receiver stalls rsp, the response register holds its transfer, the
// input register holds the next access, and req.ready drops once both are full.
module floppy_controller_no_drive
    import fdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fdc_req_if.sink    req,
    fdc_rsp_if.source  rsp
);

    logic item_valid;
    req_t item;
    logic item_take;

    fdc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    fdc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .rsp        (rsp)
    );

endmodule

[sv/fdc_in_stage.sv]
// Input register of the floppy controller: holds one bus access for the core.
// Depends on fdc_pkg and fdc_if.
module fdc_in_stage
    import fdc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    fdc_req_if.sink      req,
    output logic         item_valid,
    output req_t         item,
    input  logic         item_take
);

    logic valid_reg;
    logic valid_next;
    req_t item_reg;
    logic accept;

    // A held access may be replaced in the same cycle that the core takes it.
    assign req.ready = !valid_reg || item_take;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.func       <= func_t'(req.func);
            item_reg.write_byte <= req.write_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[sv/fdc_core.sv]
// Command and result state of the floppy controller, with the response register.
// Depends on fdc_pkg, fdc_if and the assertion macro header.
`include "floppy_controller_no_drive_macros.svh"

module fdc_core
    import fdc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  req_t         item,
    output logic         item_take,
    fdc_rsp_if.source    rsp
);

    logic       rp_reg,    rp_next;
    logic [7:0] head0_reg, head0_next;
    logic [7:0] head1_reg, head1_next;
    logic [3:0] rx_reg,    rx_next;
    logic [3:0] exp_reg,   exp_next;
    logic [7:0] rb0_reg,   rb0_next;
    logic [7:0] rb1_reg,   rb1_next;
    logic [1:0] rc_reg,    rc_next;
    logic [1:0] ri_reg,    ri_next;
    logic       pend_reg,  pend_next;
    logic [1:0] drive_reg, drive_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_irq_reg;

    logic       fire;
    logic [7:0] rd_byte;

    // The core takes an access whenever the response
    // register is free or is being emptied.
    assign item_take = item_valid && (!out_valid_reg || rsp.ready);
    assign fire      = item_take;

    always_comb
    begin
        logic [3:0] rx_base;
        logic [4:0] op;

        rp_next    = rp_reg;
        head0_next = head0_reg;
        head1_next = head1_reg;
        rx_next    = rx_reg;
        exp_next   = exp_reg;
        rb0_next   = rb0_reg;
        rb1_next   = rb1_reg;
        rc_next    = rc_reg;
        ri_next    = ri_reg;
        pend_next  = pend_reg;
        drive_next = drive_reg;
        rd_byte    = 8'h00;
        rx_base    = 4'd0;
        op         = 5'd0;

        if (fire)
        begin
            unique case (item.func)
                FUNC_RD_STATUS:
                begin
                    if (rp_reg)
                    begin
                        rd_byte = MSR_RESULT;
                    end
                    else if (rx_reg != 4'd0)
                    begin
                        rd_byte = MSR_BUSY;
                    end
                    else
                    begin
                        rd_byte = MSR_IDLE;
                    end
                end
                FUNC_RD_DATA:
                begin
                    if (rp_reg && (ri_reg < rc_reg) && (ri_reg <= 2'd1))
                    begin
                        rd_byte = ri_reg[0] ? rb1_reg : rb0_reg;
                        ri_next = ri_reg + 2'd1;
                        if (ri_next >= rc_reg)
                        begin
                            rp_next = 1'b0;
                            rx_next = 4'd0;
                            rc_next = 2'd0;
                            ri_next = 2'd0;
                        end
                    end
                end
                FUNC_WR_DATA:
                begin
                    // A write in the result phase drops the unread results.
                    if (rp_reg)
                    begin
                        rp_next = 1'b0;
                        rc_next = 2'd0;
                        ri_next = 2'd0;
                        rx_base = 4'd0;
                    end
                    else
                    begin
                        rx_base = rx_reg;
                    end

                    if (rx_base == 4'd0)
                    begin
                        head0_next = item.write_byte;
                        rx_next    = 4'd1;
                        exp_next   = 4'd1 + param_count(item.write_byte[4:0]);
                    end
                    else if (rx_base < MAX_CMD_BYTES)
                    begin
                        if (rx_base == 4'd1)
                        begin
                            head1_next = item.write_byte;
                        end
                        rx_next = rx_base + 4'd1;
                    end
                    else
                    begin
                        rx_next = rx_base;
                    end

                    if (rx_next >= exp_next)
                    begin
                        op      = head0_next[4:0];
                        ri_next = 2'd0;
                        unique case (op) inside
                            OP_SPECIFY:
                            begin
                                rp_next = 1'b0;
                                rx_next = 4'd0;
                                rc_next = 2'd0;
                            end
                            OP_SENSE_INT:
                            begin
                                if (pend_reg)
                                begin
                                    rb0_next  = ST0_SEEK_END | {6'd0, drive_reg};
                                    rb1_next  = 8'h00;
                                    rc_next   = 2'd2;
                                    pend_next = 1'b0;
                                end
                                else
                                begin
                                    rb0_next = ST0_INVALID;
                                    rc_next  = 2'd1;
                                end
                                rp_next = 1'b1;
                                rx_next = 4'd0;
                            end
                            OP_SENSE_DRIVE:
                            begin
                                drive_next = head1_next[1:0];
                                rb0_next   = {6'd0, head1_next[1:0]};
                                rc_next    = 2'd1;
                                rp_next    = 1'b1;
                                rx_next    = 4'd0;
                            end
                            OP_RECALIBRATE, OP_SEEK, OP_READ_ID, OP_READ_DATA,
                            OP_WRITE_DATA, OP_READ_TRACK, OP_READ_DEL,
                            OP_WRITE_DEL, OP_FORMAT:
                            begin
                                drive_next = head1_next[1:0];
                                pend_next  = 1'b1;
                                rp_next    = 1'b0;
                                rx_next    = 4'd0;
                                rc_next    = 2'd0;
                            end
                            default:
                            begin
                                rb0_next = ST0_INVALID;
                                rc_next  = 2'd1;
                                rp_next  = 1'b1;
                                rx_next  = 4'd0;
                            end
                        endcase
                    end
                end
                FUNC_WR_DRIVE:
                begin
                    drive_next = item.write_byte[1:0];
                end
                default:
                begin
                    rd_byte = 8'h00;
                end
            endcase
        end
    end

    assign out_valid_next = fire || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg        <= 1'b0;
            head0_reg     <= 8'h00;
            head1_reg     <= 8'h00;
            rx_reg        <= 4'd0;
            exp_reg       <= 4'd0;
            rb0_reg       <= 8'h00;
            rb1_reg       <= 8'h00;
            rc_reg        <= 2'd0;
            ri_reg        <= 2'd0;
            pend_reg      <= 1'b0;
            drive_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rp_reg        <= rp_next;
            head0_reg     <= head0_next;
            head1_reg     <= head1_next;
            rx_reg        <= rx_next;
            exp_reg       <= exp_next;
            rb0_reg       <= rb0_next;
            rb1_reg       <= rb1_next;
            rc_reg        <= rc_next;
            ri_reg        <= ri_next;
            pend_reg      <= pend_next;
            drive_reg     <= drive_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg <= rd_byte;
            out_irq_reg  <= pend_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_byte   = out_byte_reg;
    assign rsp.irq_pending = out_irq_reg;

    `FDC_ASSERT(a_result_has_bytes, rp_reg |-> (ri_reg < rc_reg), "result phase without unread bytes")
    `FDC_ASSERT(a_cmd_phase_clean, !rp_reg |-> (rc_reg == 2'd0 && ri_reg == 2'd0), "stale result state in command phase")
    `FDC_ASSERT_NEVER(a_no_partial_in_result, rp_reg && (rx_reg != 4'd0), "partial command held in result phase")
    `FDC_ASSERT(a_fire_gives_response, fire |=> out_valid_reg, "accepted access produced no response")
    `FDC_ASSERT(a_irq_from_command, $rose(pend_reg) |-> ($past(fire) && $past(item.func) == FUNC_WR_DATA), "interrupt raised without a command write")

endmodule
